// ===== design/trie_transition_table_defines.svh =====
// Assertion macros shared by the checker files of this block.
`ifndef TRIE_TRANSITION_TABLE_DEFINES_SVH
`define TRIE_TRANSITION_TABLE_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define TTT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trie_transition_table: same-cycle check failed");

// Next-cycle implication, switched off while reset is held.
`define TTT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trie_transition_table: next-cycle check failed");

// Condition that must hold in the cycle after reset is sampled low.
`define TTT_ASSERT_RESET(label, clk, rst_n, cons) \
  label: assert property (@(posedge clk) (!rst_n) |=> (cons)) \
    else $error("trie_transition_table: reset check failed");

`endif

// ===== design/ttt_pkg.sv =====
package ttt_pkg;

  // Default sizes of the trie.
  localparam int NODE_COUNT_DEF    = 64;
  localparam int ALPHABET_SIZE_DEF = 256;

  // Fixed widths of the item fields.
  localparam int SYMBOL_W   = 8;
  localparam int NODE_OUT_W = 6;

  // Operation codes carried by an input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

endpackage

// ===== design/ttt_if.sv =====
// Input channel: one byte of a word per item.
interface ttt_in_if import ttt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [SYMBOL_W-1:0] symbol;
  logic                last;

  modport source (output valid, output op, output symbol, output last, input ready);
  modport sink   (input valid, input op, input symbol, input last, output ready);
endinterface

// Result channel: one result item per input item.
interface ttt_out_if import ttt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [NODE_OUT_W-1:0] node;
  logic                  word_failed;
  logic                  found;
  logic                  table_full;

  modport source (output valid, output node, output word_failed, output found,
                  output table_full, input ready);
  modport sink   (input valid, input node, input word_failed, input found,
                  input table_full, output ready);
endinterface

// ===== design/ttt_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered data.
module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/trie_transition_table.sv =====
// Trie transition table. Words arrive one byte per item with an insert or
// lookup op and a last flag; each item gives exactly one result item. The
// trie lives in one edge RAM addressed by {node, symbol}; each entry holds the
// target node plus the final mark of that target, since every node but the
// root has exactly one parent edge. The accept cycle reads the edge entry; in
// the LOOK state, once the output register is free or being taken, the block
// resolves it, writes the entry back and loads the output register, then goes
// back to idle. With the edge RAM's single read-then-write per item, no new item
// is taken before the last one is through. A waiting result does not block the
// next accept, only the resolve step behind it. After reset the block clears
// all 2**(clog2(NODE_COUNT) + clog2(ALPHABET_SIZE)) edge entries, 16384 with
// the default sizes, one entry per cycle, and takes no item meanwhile.
module trie_transition_table import ttt_pkg::*; #(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ttt_in_if.sink    in_if,
  ttt_out_if.source out_if
);

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int SYM_W   = $clog2(ALPHABET_SIZE);
  localparam int ADDR_W  = NODE_W + SYM_W;
  localparam int DEPTH   = 2 ** ADDR_W;
  localparam int ENTRY_W = NODE_W + 1;

  localparam logic [SYMBOL_W:0] ALPHA_LIM = (SYMBOL_W + 1)'(ALPHABET_SIZE);
  localparam logic [NODE_W:0]   NODE_LIM  = (NODE_W + 1)'(NODE_COUNT);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [1:0]            state_r, state_nxt;
  logic [ADDR_W-1:0]     clr_r;
  logic [NODE_W-1:0]     cursor_r;
  logic                  failed_r;
  logic [NODE_W:0]       free_r;
  logic                  op_r;
  logic [SYMBOL_W-1:0]   sym_r;
  logic                  last_r;
  logic [ADDR_W-1:0]     addr_r;

  logic                  out_valid_r;
  logic [NODE_OUT_W-1:0] out_node_r;
  logic                  out_failed_r;
  logic                  out_found_r;
  logic                  out_full_r;

  logic                  accept;
  logic                  advance;
  logic [ADDR_W-1:0]     rd_addr;
  logic [ENTRY_W-1:0]    rd_entry;
  logic [NODE_W-1:0]     tgt;
  logic                  tgt_final;
  logic                  sym_ok;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;

  logic [NODE_W-1:0]     cur_nxt;
  logic                  fail_nxt;
  logic [NODE_W:0]       free_nxt;
  logic                  found_c;
  logic                  full_c;
  logic                  wr_en;
  logic [ENTRY_W-1:0]    wr_data;
  logic [NODE_OUT_W+NODE_W-1:0] node_ext;

  // Handshakes.
  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && (state_r == ST_IDLE);
  assign advance     = (state_r == ST_LOOK) && (!out_valid_r || out_if.ready);
  assign rd_addr     = {cursor_r, in_if.symbol[SYM_W-1:0]};

  assign out_if.valid       = out_valid_r;
  assign out_if.node        = out_node_r;
  assign out_if.word_failed = out_failed_r;
  assign out_if.found       = out_found_r;
  assign out_if.table_full  = out_full_r;

  // Edge memory: target node and final mark of the target.
  ttt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_entry)
  );

  assign tgt       = rd_entry[NODE_W-1:0];
  assign tgt_final = rd_entry[NODE_W];
  assign sym_ok    = {1'b0, sym_r} < ALPHA_LIM;

  // Resolve the edge: follow it, allocate a node, or fail the word.
  always_comb begin
    cur_nxt  = cursor_r;
    fail_nxt = failed_r;
    free_nxt = free_r;
    found_c  = 1'b0;
    full_c   = 1'b0;
    wr_en    = 1'b0;
    wr_data  = '0;
    if (!failed_r) begin
      if (!sym_ok) begin
        fail_nxt = 1'b1;
      end else if (tgt != '0) begin
        cur_nxt = tgt;
        if (last_r && op_r == OP_INSERT) begin
          wr_en   = 1'b1;
          wr_data = {1'b1, tgt};
        end
        if (last_r && op_r == OP_LOOKUP) begin
          found_c = tgt_final;
        end
      end else if (op_r == OP_INSERT) begin
        if (free_r < NODE_LIM) begin
          wr_en    = 1'b1;
          wr_data  = {last_r, free_r[NODE_W-1:0]};
          cur_nxt  = free_r[NODE_W-1:0];
          free_nxt = free_r + (NODE_W + 1)'(1);
        end else begin
          full_c   = 1'b1;
          fail_nxt = 1'b1;
        end
      end else begin
        fail_nxt = 1'b1;
      end
    end
  end

  assign node_ext = {NODE_OUT_W'(0), cur_nxt};

  // RAM write port: clearing pass after reset, else write-back of an item.
  always_comb begin
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = advance && wr_en;
      ram_waddr = addr_r;
      ram_wdata = wr_data;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (advance) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      cursor_r    <= '0;
      failed_r    <= 1'b0;
      free_r      <= (NODE_W + 1)'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + ADDR_W'(1);
      end
      if (advance) begin
        cursor_r    <= last_r ? '0 : cur_nxt;
        failed_r    <= last_r ? 1'b0 : fail_nxt;
        free_r      <= free_nxt;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Item and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_if.op;
      sym_r  <= in_if.symbol;
      last_r <= in_if.last;
      addr_r <= rd_addr;
    end
    if (advance) begin
      out_node_r   <= node_ext[NODE_OUT_W-1:0];
      out_failed_r <= fail_nxt;
      out_found_r  <= found_c;
      out_full_r   <= full_c;
    end
  end

endmodule

// ===== design/ttt_checker.sv =====
`include "trie_transition_table_defines.svh"

// Port-level checks of the trie transition table.
module ttt_checker import ttt_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [NODE_OUT_W-1:0] node,
  input logic                  word_failed,
  input logic                  found,
  input logic                  table_full
);

  // Whole result payload, so that one stability check covers every field.
  logic [NODE_OUT_W+2:0] out_payload;

  assign out_payload = {node, word_failed, found, table_full};

  // A stalled result item holds its payload.
  `TTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload))

  // A word reported as found never failed.
  `TTT_ASSERT_IMPL(a_found_not_failed, clk, rst_n, out_valid && found, !word_failed)

  // Running out of nodes fails the word.
  `TTT_ASSERT_IMPL(a_full_fails, clk, rst_n, out_valid && table_full, word_failed)

  // Reset empties the output and starts the clearing pass.
  `TTT_ASSERT_RESET(a_reset_quiet, clk, rst_n, !out_valid && !in_ready)

endmodule

bind trie_transition_table ttt_checker u_ttt_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .node        (out_if.node),
  .word_failed (out_if.word_failed),
  .found       (out_if.found),
  .table_full  (out_if.table_full)
);

// ===== tb/sv/tb.sv =====
module tb;
  import ttt_pkg::*;

  localparam int ITEM_TARGET = 1800;
  localparam int CALM_FROM   = 1500;
  localparam int MAX_WORD    = 6;
  localparam int DRAIN_WAIT  = 20;

  // One result item as the block reports it.
  typedef struct packed {
    logic [NODE_OUT_W-1:0] node;
    logic                  word_failed;
    logic                  found;
    logic                  table_full;
  } trie_result_t;

  // How the bytes of one word pick their op.
  typedef enum int {MODE_INSERT, MODE_LOOKUP, MODE_MIXED} word_mode_t;

  // Scoreboard: tracks its own trie and queues the result each byte should give.
  class trie_scoreboard;
    logic [NODE_OUT_W-1:0] child_of [0:NODE_COUNT_DEF-1][0:ALPHABET_SIZE_DEF-1];
    bit                    is_final [0:NODE_COUNT_DEF-1];
    int                    free_node;
    int                    cursor;
    bit                    word_dead;
    trie_result_t          expected_q[$];
    int                    errors;
    int                    checked;
    int                    found_hits;
    int                    full_hits;
    int                    words_done;

    function new();
      for (int n = 0; n < NODE_COUNT_DEF; n++) begin
        is_final[n] = 1'b0;
        for (int s = 0; s < ALPHABET_SIZE_DEF; s++) child_of[n][s] = '0;
      end
      free_node  = 1;
      cursor     = 0;
      word_dead  = 1'b0;
      errors     = 0;
      checked    = 0;
      found_hits = 0;
      full_hits  = 0;
      words_done = 0;
    endfunction

    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    // Walk one accepted byte through the trie and queue its result.
    function void note_byte(logic op, logic [SYMBOL_W-1:0] sym, logic last_b);
      trie_result_t exp;
      int           next;
      exp = '0;
      if (!word_dead) begin
        next = int'(child_of[cursor][sym]);
        if (next != 0) begin
          cursor = next;
        end else if (op == OP_INSERT) begin
          if (free_node < NODE_COUNT_DEF) begin
            child_of[cursor][sym] = NODE_OUT_W'(free_node);
            cursor = free_node;
            free_node++;
          end else begin
            exp.table_full = 1'b1;
            word_dead = 1'b1;
          end
        end else begin
          word_dead = 1'b1;
        end
        // The op of the last byte decides between marking and reporting.
        if (last_b && !word_dead) begin
          if (op == OP_INSERT) is_final[cursor] = 1'b1;
          else exp.found = is_final[cursor];
        end
      end
      exp.node        = NODE_OUT_W'(cursor);
      exp.word_failed = word_dead;
      found_hits += exp.found;
      full_hits  += exp.table_full;
      expected_q.push_back(exp);
      if (last_b) begin
        cursor    = 0;
        word_dead = 1'b0;
        words_done++;
      end
    endfunction

    task check_result(trie_result_t got);
      trie_result_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with no item waiting, node %0d", got.node));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.node !== exp.node)
        report_mismatch($sformatf("result %0d node %0d, want %0d", checked, got.node, exp.node));
      if (got.word_failed !== exp.word_failed)
        report_mismatch($sformatf("result %0d word_failed %0b, want %0b", checked,
                                  got.word_failed, exp.word_failed));
      if (got.found !== exp.found)
        report_mismatch($sformatf("result %0d found %0b, want %0b", checked,
                                  got.found, exp.found));
      if (got.table_full !== exp.table_full)
        report_mismatch($sformatf("result %0d table_full %0b, want %0b", checked,
                                  got.table_full, exp.table_full));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit   idle_on;
  int   items_sent;

  trie_scoreboard sb;

  ttt_in_if  in_ch ();
  ttt_out_if out_ch ();

  trie_transition_table dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stall bursts while idling is on.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
    end
  end

  // Every accepted result goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.node, out_ch.word_failed, out_ch.found, out_ch.table_full});
  end

  // Present one byte, with an optional gap in front, and wait until it is taken.
  task automatic send_byte(logic op, logic [SYMBOL_W-1:0] sym, logic last_b);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.op     <= op;
    in_ch.symbol <= sym;
    in_ch.last   <= last_b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_byte(op, sym, last_b);
    items_sent++;
  endtask

  task automatic send_word(logic [8*MAX_WORD-1:0] bytes, int len, word_mode_t mode);
    logic op;
    for (int i = 0; i < len; i++) begin
      case (mode)
        MODE_INSERT: op = OP_INSERT;
        MODE_LOOKUP: op = OP_LOOKUP;
        default:     op = $urandom_range(0, 1) ? OP_LOOKUP : OP_INSERT;
      endcase
      send_byte(op, bytes[8*i +: 8], i == len - 1);
    end
  endtask

  // Mostly a few recurring bytes so edges get shared, sometimes any byte.
  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2, 3:    return 8'hFF;
      4:       return 8'h5A;
      5:       return 8'hA5;
      default: return SYMBOL_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [8*MAX_WORD-1:0] random_word(int len);
    logic [8*MAX_WORD-1:0] w;
    w = '0;
    for (int i = 0; i < len; i++) w[8*i +: 8] = pick_symbol();
    return w;
  endfunction

  initial begin
    logic [8*MAX_WORD-1:0] word_bank[$];
    int                    len_bank[$];
    logic [8*MAX_WORD-1:0] w;
    int                    len;
    int                    kind;
    int                    pick;

    sb           = new();
    idle_on      = 1'b1;
    items_sent   = 0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.op     <= OP_INSERT;
    in_ch.symbol <= '0;
    in_ch.last   <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words; byte 0 of a word sits in the low bits.
    send_word(48'h00, 1, MODE_INSERT);          // new word from the root
    send_word(48'h00, 1, MODE_LOOKUP);          // found
    send_word(48'h01FF, 2, MODE_INSERT);        // two new nodes
    send_word(48'hFF, 1, MODE_LOOKUP);          // prefix that is not final
    send_word(48'h01FF, 2, MODE_LOOKUP);        // found
    send_word(48'h7E, 1, MODE_LOOKUP);          // missing edge
    send_word(48'h01007E, 3, MODE_LOOKUP);      // failed word keeps going
    send_word(48'h01FF, 2, MODE_INSERT);        // word already present
    send_byte(OP_INSERT, 8'hAA, 1'b0);          // mixed: lookup ends on a missing edge
    send_byte(OP_LOOKUP, 8'h55, 1'b1);
    send_byte(OP_LOOKUP, 8'hFF, 1'b0);          // mixed: insert ends and marks final
    send_byte(OP_INSERT, 8'h02, 1'b1);
    send_word(48'h02FF, 2, MODE_LOOKUP);
    send_word(48'hFF, 1, MODE_INSERT);          // existing inner node becomes final
    send_word(48'hFF, 1, MODE_LOOKUP);
    send_word(48'hAA, 1, MODE_LOOKUP);          // not final after the mixed word

    // Hold the sender back until the block has drained.
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);

    // Random words: mostly inserts and lookups of words seen before.
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= CALM_FROM) idle_on = 1'b0;
      kind = $urandom_range(0, 99);
      len  = $urandom_range(1, 5);
      w    = random_word(len);
      if (kind >= 30 && kind < 85 && word_bank.size() != 0) begin
        pick = $urandom_range(0, word_bank.size() - 1);
        w    = word_bank[pick];
        len  = len_bank[pick];
        if (kind >= 65 && kind < 75) begin
          // Shorter prefix or one byte longer.
          if ($urandom_range(0, 1)) len = $urandom_range(1, len);
          else if (len < MAX_WORD) begin
            w[8*len +: 8] = pick_symbol();
            len++;
          end
        end
      end
      if (kind < 30) begin
        send_word(w, len, MODE_INSERT);
        word_bank.push_back(w);
        len_bank.push_back(len);
      end else if (kind >= 75 && kind < 85) begin
        send_word(w, len, MODE_INSERT);
      end else if (kind >= 93) begin
        send_word(w, len, MODE_MIXED);
      end else begin
        send_word(w, len, MODE_LOOKUP);
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d bytes in %0d words; %0d results checked.", items_sent,
             sb.words_done, sb.checked);
    $display("%0d lookups found their word, %0d inserts ran out of nodes, %0d mismatches.",
             sb.found_hits, sb.full_hits, sb.errors);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
